// ----- src/gpg_pkg.sv -----
// Shared types, constants and gait tables for the gait phase generator.
// No dependencies; every other file in src refers to this package by scoped name.
package gpg_pkg;

  // Number of legs and number of defined gaits.
  localparam int unsigned NUM_LEGS   = 6;
  localparam int unsigned GAIT_COUNT = 6;

  // Default number of phase points in one gait cycle.
  localparam int unsigned PHASE_POINTS_DEF = 1000;

  // Depth of the queue between the step front end and the phase back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths.
  localparam int unsigned GAIT_W   = 3;
  localparam int unsigned FWD_W    = 15;
  localparam int unsigned TURN_W   = 16;
  localparam int unsigned SLIDER_W = 7;
  localparam int unsigned OPHASE_W = 10;
  localparam int unsigned STEP_W   = 8;

  // Gait codes.
  localparam logic [GAIT_W-1:0] GAIT_TRIPOD = 3'd0;
  localparam logic [GAIT_W-1:0] GAIT_WAVE   = 3'd1;
  localparam logic [GAIT_W-1:0] GAIT_RIPPLE = 3'd2;
  localparam logic [GAIT_W-1:0] GAIT_BI     = 3'd3;
  localparam logic [GAIT_W-1:0] GAIT_QUAD   = 3'd4;
  localparam logic [GAIT_W-1:0] GAIT_HOP    = 3'd5;

  // Slider offset: the speed factor is (slider + 10) / 100.
  localparam logic [7:0] SLIDER_BIAS = 8'd10;

  // Division of the speed product by 256000 is a shift by 11 and then a
  // division by 125.  Quotients above 275 never win the minimum, so the
  // dividend is clamped first, and within that range the reciprocal
  // multiply below is exact.
  localparam int unsigned     ADIV_PRE_SHIFT = 11;
  localparam logic [15:0]     Y_CLAMP        = 16'd34375;
  localparam logic [16:0]     ADIV_RECIP     = 17'd67109;  // ceil(2^23 / 125)
  // Division of the limit product by 100 is a shift by 2 and then a
  // division by 25, exact for dividends up to 6850.
  localparam logic [15:0]     BDIV_RECIP     = 16'd41944;  // ceil(2^20 / 25)

  // Largest step that can be reported.
  localparam logic [8:0] STEP_SAT = 9'd255;

  // Leg mode codes.
  typedef enum logic [1:0] {
    MODE_PROPEL = 2'd0,
    MODE_LIFT   = 2'd1,
    MODE_RESET  = 2'd3
  } gpg_mode_e;

  // Control word that travels with each step through the queue.
  typedef struct packed {
    logic                enter;
    logic [STEP_W-1:0]   step;
  } gpg_step_t;

  // Forward speed in tenths for each gait.
  function automatic logic [5:0] speed_tenths(input logic [GAIT_W-1:0] gait);
    logic [5:0] val;
    case (gait)
      GAIT_WAVE: val = 6'd4;
      GAIT_BI:   val = 6'd40;
      default:   val = 6'd10;
    endcase
    return val;
  endfunction

  // Maximum speed for each gait.
  function automatic logic [7:0] max_speed(input logic [GAIT_W-1:0] gait);
    logic [7:0] val;
    case (gait)
      GAIT_WAVE: val = 8'd160;
      GAIT_BI:   val = 8'd130;
      default:   val = 8'd200;
    endcase
    return val;
  endfunction

  // Starting phase of each leg in sixths of a cycle.
  function automatic logic [2:0] offset_sixths(input logic [GAIT_W-1:0] gait,
                                               input logic [2:0] leg);
    logic [2:0] val;
    val = 3'd0;
    case (gait)
      GAIT_WAVE: begin
        case (leg)
          3'd1:    val = 3'd1;
          3'd2:    val = 3'd2;
          3'd3:    val = 3'd5;
          3'd4:    val = 3'd4;
          3'd5:    val = 3'd3;
          default: val = 3'd0;
        endcase
      end
      GAIT_RIPPLE: begin
        case (leg)
          3'd1:    val = 3'd4;
          3'd2:    val = 3'd2;
          3'd3:    val = 3'd5;
          3'd4:    val = 3'd1;
          3'd5:    val = 3'd3;
          default: val = 3'd0;
        endcase
      end
      GAIT_BI, GAIT_QUAD: begin
        case (leg)
          3'd1, 3'd4: val = 3'd2;
          3'd2, 3'd5: val = 3'd4;
          default:    val = 3'd0;
        endcase
      end
      GAIT_HOP: val = 3'd0;
      default: begin
        val = leg[0] ? 3'd3 : 3'd0;
      end
    endcase
    return val;
  endfunction

endpackage

// ----- src/gpg_front.sv -----
// Step front end: accepts control ticks and computes the common phase step.
// Depends on gpg_pkg for gait tables and division constants.
module gpg_front #(
  parameter int unsigned PHASE_POINTS = gpg_pkg::PHASE_POINTS_DEF,
  localparam int unsigned PhaseW = $clog2(PHASE_POINTS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [gpg_pkg::GAIT_W-1:0]        gait_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gpg_pkg::FWD_W-1:0]         forward_magnitude_i,
  input  logic signed [gpg_pkg::TURN_W-1:0] turn_amount_i,
  input  logic [gpg_pkg::SLIDER_W-1:0]      speed_slider_i,
  input  logic                              enter_walk_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output gpg_pkg::gpg_step_t                out_ctrl_o,
  output logic [PhaseW-1:0]                 out_step_mod_o
);

  localparam int unsigned ModW     = ((PhaseW > 8) ? PhaseW : 8) + 1;
  localparam int unsigned ModSteps = 255 / PHASE_POINTS;

  // Pipeline control: all stages move together when the last one can drain.
  logic adv;
  logic v1_q, v2_q, v3_q;

  assign adv        = !v3_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 0: magnitude, speed factor and the first products.
  logic [15:0] turn_bits, turn_abs, mag;
  logic [7:0]  fac;
  logic [15:0] lim_prod;
  logic [21:0] p1_d;
  logic [12:0] bz_d;

  always_comb begin
    turn_bits = turn_amount_i;
    turn_abs  = turn_bits[15] ? (~turn_bits + 16'd1) : turn_bits;
    mag       = ({1'b0, forward_magnitude_i} > turn_abs) ? {1'b0, forward_magnitude_i}
                                                         : turn_abs;
    fac       = 8'(speed_slider_i) + gpg_pkg::SLIDER_BIAS;
    p1_d      = 22'(mag) * 22'(gpg_pkg::speed_tenths(gait_i));
    lim_prod  = 16'(gpg_pkg::max_speed(gait_i)) * 16'(fac);
    bz_d      = lim_prod[14:2];
  end

  logic [21:0] p1_q;
  logic [7:0]  fac_q;
  logic [12:0] bz_q;
  logic        en1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q  <= p1_d;
      fac_q <= fac;
      bz_q  <= bz_d;
      en1_q <= enter_walk_i;
    end
  end

  // Stage 1: full speed product and the speed limit quotient.
  logic [29:0] p2;
  logic [18:0] y_full;
  logic [15:0] yc_d;
  logic [28:0] bprod;
  logic [8:0]  b_d;

  always_comb begin
    p2     = 30'(p1_q) * 30'(fac_q);
    y_full = p2[29:gpg_pkg::ADIV_PRE_SHIFT];
    yc_d   = (y_full > 19'(gpg_pkg::Y_CLAMP)) ? gpg_pkg::Y_CLAMP : y_full[15:0];
    bprod  = 29'(bz_q) * 29'(gpg_pkg::BDIV_RECIP);
    b_d    = bprod[28:20];
  end

  logic [15:0] yc_q;
  logic [8:0]  b_q;
  logic        en2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yc_q  <= yc_d;
      b_q   <= b_d;
      en2_q <= en1_q;
    end
  end

  // Stage 2: speed quotient, minimum, saturation and reduction into the cycle.
  logic [32:0]     aprod;
  logic [8:0]      a_val, smin;
  logic [7:0]      step_d;
  logic [ModW-1:0] red;

  always_comb begin
    aprod  = 33'(yc_q) * 33'(gpg_pkg::ADIV_RECIP);
    a_val  = aprod[31:23];
    smin   = (a_val < b_q) ? a_val : b_q;
    step_d = (smin > gpg_pkg::STEP_SAT) ? gpg_pkg::STEP_SAT[7:0] : smin[7:0];
    red    = ModW'(step_d);
    for (int k = 0; k < ModSteps; k++) begin
      if (red >= ModW'(PHASE_POINTS)) begin
        red = red - ModW'(PHASE_POINTS);
      end
    end
  end

  gpg_pkg::gpg_step_t ctrl_q;
  logic [PhaseW-1:0]  step_mod_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q.enter <= en2_q;
      ctrl_q.step  <= step_d;
      step_mod_q   <= red[PhaseW-1:0];
    end
  end

  assign out_valid_o    = v3_q;
  assign out_ctrl_o     = ctrl_q;
  assign out_step_mod_o = step_mod_q;

endmodule

// ----- src/gpg_queue.sv -----
// Small flip-flop queue that decouples the step front end from the phase back end.
// Depends on gpg_pkg only for its default depth.
module gpg_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = gpg_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Storage is written only at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/gpg_back.sv -----
// Phase back end: holds leg phases and modes, classifies legs and advances phases.
// Depends on gpg_pkg for gait tables, mode codes and the step word type.
module gpg_back #(
  parameter int unsigned PHASE_POINTS = gpg_pkg::PHASE_POINTS_DEF,
  localparam int unsigned PhaseW = $clog2(PHASE_POINTS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [gpg_pkg::GAIT_W-1:0]       gait_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  gpg_pkg::gpg_step_t               in_ctrl_i,
  input  logic [PhaseW-1:0]                in_step_mod_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gpg_pkg::OPHASE_W-1:0]     leg_phase_o [gpg_pkg::NUM_LEGS],
  output logic [gpg_pkg::NUM_LEGS-1:0]     propel_mask_o,
  output logic [gpg_pkg::NUM_LEGS-1:0]     entered_mask_o,
  output logic [gpg_pkg::STEP_W-1:0]       step_size_o
);

  localparam int unsigned NumLegs = gpg_pkg::NUM_LEGS;
  localparam int unsigned OutW    = gpg_pkg::OPHASE_W;

  // Starting phase for each number of sixths.
  localparam logic [PhaseW-1:0] OFF_TAB [6] = '{
    PhaseW'(0),
    PhaseW'(PHASE_POINTS / 6),
    PhaseW'((2 * PHASE_POINTS) / 6),
    PhaseW'((3 * PHASE_POINTS) / 6),
    PhaseW'((4 * PHASE_POINTS) / 6),
    PhaseW'((5 * PHASE_POINTS) / 6)
  };

  // A leg propels while its phase is below ceil(n * points / 60), n per gait.
  localparam logic [PhaseW-1:0] TH_TAB [6] = '{
    PhaseW'((31 * PHASE_POINTS + 59) / 60),
    PhaseW'((50 * PHASE_POINTS + 59) / 60),
    PhaseW'((32 * PHASE_POINTS + 59) / 60),
    PhaseW'((21 * PHASE_POINTS + 59) / 60),
    PhaseW'((41 * PHASE_POINTS + 59) / 60),
    PhaseW'((30 * PHASE_POINTS + 59) / 60)
  };

  logic [PhaseW-1:0]        phase_q [NumLegs];
  gpg_pkg::gpg_mode_e       mode_q  [NumLegs];
  logic [gpg_pkg::GAIT_W-1:0] used_gait_q;
  logic                     primed_q;
  logic                     out_valid_q;

  logic take;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // Per-leg classification and advance for the word at the queue head.
  logic                 reinit;
  logic [PhaseW-1:0]    cur     [NumLegs];
  logic [PhaseW-1:0]    nxt     [NumLegs];
  gpg_pkg::gpg_mode_e   new_mode[NumLegs];
  logic [PhaseW:0]      sum     [NumLegs];
  logic [PhaseW+OutW-1:0] cur_ext [NumLegs];
  logic [NumLegs-1:0]   propel_d, entered_d;

  always_comb begin
    reinit = !primed_q || in_ctrl_i.enter || (used_gait_q != gait_i);
    for (int i = 0; i < NumLegs; i++) begin
      cur[i] = reinit ? OFF_TAB[gpg_pkg::offset_sixths(gait_i, 3'(i))] : phase_q[i];
      propel_d[i]  = (cur[i] < TH_TAB[gait_i]);
      new_mode[i]  = propel_d[i] ? gpg_pkg::MODE_PROPEL : gpg_pkg::MODE_LIFT;
      entered_d[i] = reinit ? 1'b1 : (new_mode[i] != mode_q[i]);
      sum[i]       = {1'b0, cur[i]} + {1'b0, in_step_mod_i};
      nxt[i]       = (sum[i] >= (PhaseW + 1)'(PHASE_POINTS))
                     ? PhaseW'(sum[i] - (PhaseW + 1)'(PHASE_POINTS))
                     : sum[i][PhaseW-1:0];
      cur_ext[i]   = (PhaseW + OutW)'(cur[i]);
    end
  end

  // Leg state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLegs; i++) begin
        phase_q[i] <= '0;
        mode_q[i]  <= gpg_pkg::MODE_RESET;
      end
      used_gait_q <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < NumLegs; i++) begin
          phase_q[i] <= nxt[i];
          mode_q[i]  <= new_mode[i];
        end
        used_gait_q <= gait_i;
        primed_q    <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word register.
  logic [OutW-1:0]    phase_out_q [NumLegs];
  logic [NumLegs-1:0] propel_q, entered_q;
  logic [7:0]         step_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < NumLegs; i++) begin
        phase_out_q[i] <= cur_ext[i][OutW-1:0];
      end
      propel_q  <= propel_d;
      entered_q <= entered_d;
      step_q    <= in_ctrl_i.step;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign leg_phase_o    = phase_out_q;
  assign propel_mask_o  = propel_q;
  assign entered_mask_o = entered_q;
  assign step_size_o    = step_q;

endmodule

// ----- src/gait_phase_generator_top.sv -----
// Top level of the six-leg gait phase generator: gait register, front end, queue, back end.
// Depends on gpg_pkg, gpg_front, gpg_queue and gpg_back.
//
//   Channel  Direction  Handshake                 Word
//   cfg      in         cfg_valid_i/cfg_ready_o   gait select
//   in       in         in_valid_i/in_ready_o     one control tick
//   out      out        out_valid_o/out_ready_i   leg phases, masks, step size
//
// After a tick is accepted, the acceptance edge loads the first of three step
// stages, the two later stages finish the step, the word waits in the queue and
// the back end works on the six legs and registers the result word.  Both the
// step pipeline and the back end take one word per cycle unless the output stalls.
// A two-word queue lets the step pipeline keep filling while the output stalls.
// Reset puts every phase at zero, every leg mode at reset and the gait at tripod.
module gait_phase_generator_top #(
  parameter int unsigned PHASE_POINTS = gpg_pkg::PHASE_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gpg_pkg::GAIT_W-1:0]        cfg_gait_select_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gpg_pkg::FWD_W-1:0]         forward_magnitude_i,
  input  logic signed [gpg_pkg::TURN_W-1:0] turn_amount_i,
  input  logic [gpg_pkg::SLIDER_W-1:0]      speed_slider_i,
  input  logic                              enter_walk_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gpg_pkg::OPHASE_W-1:0]      leg0_phase_o,
  output logic [gpg_pkg::OPHASE_W-1:0]      leg1_phase_o,
  output logic [gpg_pkg::OPHASE_W-1:0]      leg2_phase_o,
  output logic [gpg_pkg::OPHASE_W-1:0]      leg3_phase_o,
  output logic [gpg_pkg::OPHASE_W-1:0]      leg4_phase_o,
  output logic [gpg_pkg::OPHASE_W-1:0]      leg5_phase_o,
  output logic [gpg_pkg::NUM_LEGS-1:0]      propel_mask_o,
  output logic [gpg_pkg::NUM_LEGS-1:0]      entered_mask_o,
  output logic [gpg_pkg::STEP_W-1:0]        step_size_o
);

  localparam int unsigned PhaseW = $clog2(PHASE_POINTS);
  localparam int unsigned QDataW = $bits(gpg_pkg::gpg_step_t) + PhaseW;

  // Gait register; unused codes act as tripod.
  logic [gpg_pkg::GAIT_W-1:0] gait_sel_q, gait_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gait_sel_q <= gpg_pkg::GAIT_TRIPOD;
    end else if (cfg_valid_i) begin
      gait_sel_q <= cfg_gait_select_i;
    end
  end

  assign gait_eff = (gait_sel_q > gpg_pkg::GAIT_HOP) ? gpg_pkg::GAIT_TRIPOD : gait_sel_q;

  // Step front end.
  logic               f_valid, f_ready;
  gpg_pkg::gpg_step_t f_ctrl;
  logic [PhaseW-1:0]  f_step_mod;

  gpg_front #(
    .PHASE_POINTS(PHASE_POINTS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .gait_i             (gait_eff),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .forward_magnitude_i(forward_magnitude_i),
    .turn_amount_i      (turn_amount_i),
    .speed_slider_i     (speed_slider_i),
    .enter_walk_i       (enter_walk_i),
    .out_valid_o        (f_valid),
    .out_ready_i        (f_ready),
    .out_ctrl_o         (f_ctrl),
    .out_step_mod_o     (f_step_mod)
  );

  // Queue between the two halves.
  logic              q_valid, q_ready;
  logic [QDataW-1:0] q_data;

  gpg_queue #(
    .DATA_W(QDataW),
    .DEPTH (gpg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i ({f_ctrl, f_step_mod}),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  gpg_pkg::gpg_step_t b_ctrl;
  logic [PhaseW-1:0]  b_step_mod;

  assign b_ctrl     = q_data[QDataW-1:PhaseW];
  assign b_step_mod = q_data[PhaseW-1:0];

  // Phase back end.
  logic [gpg_pkg::OPHASE_W-1:0] leg_phase [gpg_pkg::NUM_LEGS];

  gpg_back #(
    .PHASE_POINTS(PHASE_POINTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gait_i        (gait_eff),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_ctrl_i     (b_ctrl),
    .in_step_mod_i (b_step_mod),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .leg_phase_o   (leg_phase),
    .propel_mask_o (propel_mask_o),
    .entered_mask_o(entered_mask_o),
    .step_size_o   (step_size_o)
  );

  assign leg0_phase_o = leg_phase[0];
  assign leg1_phase_o = leg_phase[1];
  assign leg2_phase_o = leg_phase[2];
  assign leg3_phase_o = leg_phase[3];
  assign leg4_phase_o = leg_phase[4];
  assign leg5_phase_o = leg_phase[5];

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for gait_phase_generator_top: a directed table of ticks,
// then random ticks per gait; every word checked against a typed row or the predictor.
// Depends on gpg_pkg and the RTL under src only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_POINTS = 1000;
  localparam int unsigned CLK_HALF_NS  = 6;
  localparam int unsigned RESET_CYCLES = 11;
  // Margin after the last result before the gait register is touched.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_TICKS   = 100;
  localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

  // Codes 6 and 7 are not defined gaits and behave as tripod.
  localparam logic [gpg_pkg::GAIT_W-1:0] GAIT_SPARE6 = 3'd6;
  localparam logic [gpg_pkg::GAIT_W-1:0] GAIT_SPARE7 = 3'd7;

  // Per-gait tables: start offsets in sixths, push threshold in tenths of a
  // sixth, speed in tenths and speed limit.
  localparam int unsigned LEG_START_SIXTHS [gpg_pkg::GAIT_COUNT][gpg_pkg::NUM_LEGS] = '{
    '{0, 3, 0, 3, 0, 3},
    '{0, 1, 2, 5, 4, 3},
    '{0, 4, 2, 5, 1, 3},
    '{0, 2, 4, 0, 2, 4},
    '{0, 2, 4, 0, 2, 4},
    '{0, 0, 0, 0, 0, 0}
  };
  localparam int unsigned PUSH_TENTHS [gpg_pkg::GAIT_COUNT] = '{31, 50, 32, 21, 41, 30};
  localparam int unsigned GAIT_SPEED  [gpg_pkg::GAIT_COUNT] = '{10, 4, 10, 40, 10, 10};
  localparam int unsigned GAIT_LIMIT  [gpg_pkg::GAIT_COUNT] =
    '{200, 160, 200, 130, 200, 200};

  typedef struct packed {
    logic [gpg_pkg::NUM_LEGS-1:0][gpg_pkg::OPHASE_W-1:0] phase;
    logic [gpg_pkg::NUM_LEGS-1:0]                         propel;
    logic [gpg_pkg::NUM_LEGS-1:0]                         entered;
    logic [gpg_pkg::STEP_W-1:0]                           step;
  } leg_report_t;

  typedef struct packed {
    logic [gpg_pkg::GAIT_W-1:0]   gait;
    logic [gpg_pkg::FWD_W-1:0]    fwd;
    logic [gpg_pkg::TURN_W-1:0]   turn;
    logic [gpg_pkg::SLIDER_W-1:0] slider;
    logic                         enter;
    logic                         typed;
    leg_report_t                  report;
  } tick_row_t;

  // Phase sets that the first rows read off directly (leg 5 first).
  localparam logic [gpg_pkg::NUM_LEGS-1:0][gpg_pkg::OPHASE_W-1:0] TRIPOD_AT_0 =
    {10'd500, 10'd0, 10'd500, 10'd0, 10'd500, 10'd0};
  localparam logic [gpg_pkg::NUM_LEGS-1:0][gpg_pkg::OPHASE_W-1:0] TRIPOD_AT_110 =
    {10'd610, 10'd110, 10'd610, 10'd110, 10'd610, 10'd110};
  localparam logic [gpg_pkg::NUM_LEGS-1:0][gpg_pkg::OPHASE_W-1:0] TRIPOD_AT_220 =
    {10'd720, 10'd220, 10'd720, 10'd220, 10'd720, 10'd220};

  localparam int DIRECTED_COUNT = 21;
  localparam tick_row_t DIRECTED_TICKS [DIRECTED_COUNT] = '{
    // First tick after reset loads the tripod offsets; all legs propel.
    '{gpg_pkg::GAIT_TRIPOD, 15'd0, 16'd0, 7'd0, 1'b0, 1'b1,
      '{TRIPOD_AT_0, 6'h3F, 6'h3F, 8'd0}},
    // Entry into walking reloads the offsets at full stick and slider.
    '{gpg_pkg::GAIT_TRIPOD, 15'd25600, 16'd0, 7'd100, 1'b1, 1'b1,
      '{TRIPOD_AT_0, 6'h3F, 6'h3F, 8'd110}},
    // Odd legs cross the push threshold and switch to lifting.
    '{gpg_pkg::GAIT_TRIPOD, 15'd0, 16'd0, 7'd0, 1'b0, 1'b1,
      '{TRIPOD_AT_110, 6'h15, 6'h2A, 8'd0}},
    // Full left turn sets the step alone.
    '{gpg_pkg::GAIT_TRIPOD, 15'd0, -16'sd25600, 7'd100, 1'b0, 1'b1,
      '{TRIPOD_AT_110, 6'h15, 6'h00, 8'd110}},
    // Field extremes: most negative turn, top slider.
    '{gpg_pkg::GAIT_TRIPOD, 15'h7FFF, 16'h8000, 7'h7F, 1'b0, 1'b1,
      '{TRIPOD_AT_220, 6'h15, 6'h00, 8'd175}},
    '{gpg_pkg::GAIT_TRIPOD, 15'h7FFF, 16'h7FFF, 7'h7F, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_WAVE,   15'd25600, 16'd0, 7'd100, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_WAVE,   15'd0, 16'd25600, 7'd0, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_RIPPLE, 15'd12800, -16'sd12800, 7'd50, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_RIPPLE, 15'd25600, 16'd25600, 7'd100, 1'b1, 1'b0, '0},
    // Bi gait: the speed limit wins, then the stick term wins.
    '{gpg_pkg::GAIT_BI,     15'd25600, 16'd0, 7'd100, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_BI,     15'd1000, 16'd0, 7'd10, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_QUAD,   15'd25600, 16'd0, 7'd100, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_QUAD,   15'd256, 16'd0, 7'd0, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_HOP,    15'd25600, 16'd0, 7'd100, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_HOP,    15'd0, 16'd0, 7'd0, 1'b1, 1'b0, '0},
    // Undefined codes run as tripod; moving between them and tripod does not reload.
    '{GAIT_SPARE7, 15'd25600, 16'd0, 7'd100, 1'b0, 1'b0, '0},
    '{GAIT_SPARE7, 15'd0, 16'd0, 7'h7F, 1'b0, 1'b0, '0},
    '{GAIT_SPARE6, 15'd25600, 16'd0, 7'd100, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_TRIPOD, 15'd0, 16'd0, 7'd0, 1'b0, 1'b0, '0},
    '{gpg_pkg::GAIT_TRIPOD, 15'd1, 16'd1, 7'd0, 1'b0, 1'b0, '0}
  };

  // Random phases walk every gait code, the extremes among them.
  localparam logic [gpg_pkg::GAIT_W-1:0] PHASE_GAITS [RANDOM_PHASES] = '{
    gpg_pkg::GAIT_TRIPOD, gpg_pkg::GAIT_WAVE, gpg_pkg::GAIT_RIPPLE, gpg_pkg::GAIT_BI,
    gpg_pkg::GAIT_QUAD, gpg_pkg::GAIT_HOP, GAIT_SPARE7, GAIT_SPARE6
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [gpg_pkg::GAIT_W-1:0]        cfg_gait_select_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [gpg_pkg::FWD_W-1:0]         forward_magnitude_i = '0;
  logic signed [gpg_pkg::TURN_W-1:0] turn_amount_i = '0;
  logic [gpg_pkg::SLIDER_W-1:0]      speed_slider_i = '0;
  logic                              enter_walk_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [gpg_pkg::OPHASE_W-1:0]      leg0_phase_o, leg1_phase_o, leg2_phase_o;
  logic [gpg_pkg::OPHASE_W-1:0]      leg3_phase_o, leg4_phase_o, leg5_phase_o;
  logic [gpg_pkg::NUM_LEGS-1:0]      propel_mask_o;
  logic [gpg_pkg::NUM_LEGS-1:0]      entered_mask_o;
  logic [gpg_pkg::STEP_W-1:0]        step_size_o;

  // Predictor state and the gait register copy.
  logic [gpg_pkg::GAIT_W-1:0] gait_reg = gpg_pkg::GAIT_TRIPOD;
  int unsigned                leg_phase [gpg_pkg::NUM_LEGS];
  gpg_pkg::gpg_mode_e         leg_mode [gpg_pkg::NUM_LEGS];
  logic [gpg_pkg::GAIT_W-1:0] used_gait = gpg_pkg::GAIT_TRIPOD;
  logic                       primed = 1'b0;

  leg_report_t pending_reports [$];
  int unsigned fault_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  gait_phase_generator_top #(
    .PHASE_POINTS(PHASE_POINTS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_gait_select_i  (cfg_gait_select_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .forward_magnitude_i(forward_magnitude_i),
    .turn_amount_i      (turn_amount_i),
    .speed_slider_i     (speed_slider_i),
    .enter_walk_i       (enter_walk_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .leg0_phase_o       (leg0_phase_o),
    .leg1_phase_o       (leg1_phase_o),
    .leg2_phase_o       (leg2_phase_o),
    .leg3_phase_o       (leg3_phase_o),
    .leg4_phase_o       (leg4_phase_o),
    .leg5_phase_o       (leg5_phase_o),
    .propel_mask_o      (propel_mask_o),
    .entered_mask_o     (entered_mask_o),
    .step_size_o        (step_size_o)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // Advances the leg state by one control tick and returns the word it reports.
  function automatic leg_report_t advance_gait(input logic [gpg_pkg::FWD_W-1:0] fwd,
                                               input logic [gpg_pkg::TURN_W-1:0] turn,
                                               input logic [gpg_pkg::SLIDER_W-1:0] slider,
                                               input logic enter);
    leg_report_t                rep;
    logic [gpg_pkg::GAIT_W-1:0] g;
    longint unsigned            turn_abs, mag, factor, by_stick, by_limit, step;
    gpg_pkg::gpg_mode_e         mode;
    g = (gait_reg > gpg_pkg::GAIT_HOP) ? gpg_pkg::GAIT_TRIPOD : gait_reg;
    // Reload the offsets on first use, on entering walking or on a gait change.
    if (!primed || enter || used_gait != g) begin
      for (int leg = 0; leg < gpg_pkg::NUM_LEGS; leg++) begin
        leg_phase[leg] = LEG_START_SIXTHS[g][leg] * PHASE_POINTS / 6;
        leg_mode[leg] = gpg_pkg::MODE_RESET;
      end
    end
    primed = 1'b1;
    used_gait = g;
    // Step from the larger stick deflection, capped by the gait's speed limit.
    turn_abs = turn[gpg_pkg::TURN_W-1] ? (64'd65536 - turn) : turn;
    mag = (fwd > turn_abs) ? fwd : turn_abs;
    factor = slider + 10;
    by_stick = mag * GAIT_SPEED[g] * factor / 256000;
    by_limit = GAIT_LIMIT[g] * factor / 100;
    step = (by_stick < by_limit) ? by_stick : by_limit;
    if (step > 255) step = 255;
    rep = '0;
    for (int leg = 0; leg < gpg_pkg::NUM_LEGS; leg++) begin
      rep.phase[leg] = (gpg_pkg::OPHASE_W)'(leg_phase[leg]);
      mode = (leg_phase[leg] * 60 < PUSH_TENTHS[g] * PHASE_POINTS) ? gpg_pkg::MODE_PROPEL
                                                                   : gpg_pkg::MODE_LIFT;
      rep.propel[leg] = (mode == gpg_pkg::MODE_PROPEL);
      rep.entered[leg] = (mode != leg_mode[leg]);
      leg_mode[leg] = mode;
      leg_phase[leg] = (leg_phase[leg] + step) % PHASE_POINTS;
    end
    rep.step = (gpg_pkg::STEP_W)'(step);
    return rep;
  endfunction

  // Offers one tick and waits for it to be taken; a typed row supplies its
  // own expected word, the predictor still advances.
  task automatic send_tick(input logic [gpg_pkg::FWD_W-1:0] fwd,
                           input logic [gpg_pkg::TURN_W-1:0] turn,
                           input logic [gpg_pkg::SLIDER_W-1:0] slider, input logic enter,
                           input logic typed, input leg_report_t typed_report);
    leg_report_t predicted;
    in_valid_i <= 1'b1;
    forward_magnitude_i <= fwd;
    turn_amount_i <= turn;
    speed_slider_i <= slider;
    enter_walk_i <= enter;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = advance_gait(fwd, turn, slider, enter);
    pending_reports.push_back(typed ? typed_report : predicted);
  endtask

  // Lets the block drain completely, then writes the gait register.
  task automatic program_gait(input logic [gpg_pkg::GAIT_W-1:0] code);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_gait_select_i <= code;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gait_reg = code;
  endtask

  // Result side: check each accepted word, then pick the next ready level.
  always @(posedge clk_i) begin : result_monitor
    leg_report_t got, want;
    if (out_valid_o && out_ready_i) begin
      got.phase = {leg5_phase_o, leg4_phase_o, leg3_phase_o,
                   leg2_phase_o, leg1_phase_o, leg0_phase_o};
      got.propel = propel_mask_o;
      got.entered = entered_mask_o;
      got.step = step_size_o;
      if (pending_reports.size() == 0) begin
        $error("result word arrived with no tick outstanding");
        fault_count++;
      end else begin
        want = pending_reports.pop_front();
        for (int leg = 0; leg < gpg_pkg::NUM_LEGS; leg++) begin
          if (got.phase[leg] !== want.phase[leg]) begin
            $error("leg%0d_phase: expected %0d, got %0d", leg, want.phase[leg],
                   got.phase[leg]);
            fault_count++;
          end
        end
        if (got.propel !== want.propel) begin
          $error("propel_mask: expected %b, got %b", want.propel, got.propel);
          fault_count++;
        end
        if (got.entered !== want.entered) begin
          $error("entered_mask: expected %b, got %b", want.entered, got.entered);
          fault_count++;
        end
        if (got.step !== want.step) begin
          $error("step_size: expected %0d, got %0d", want.step, got.step);
          fault_count++;
        end
      end
    end
    // A requested hold keeps ready low until the hold counter runs out.
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stimulus: reset, the directed table, then random ticks per gait.
  initial begin : stimulus
    tick_row_t                    row;
    logic [gpg_pkg::FWD_W-1:0]    fwd;
    logic [gpg_pkg::TURN_W-1:0]   turn;
    logic [gpg_pkg::SLIDER_W-1:0] slider;
    logic                         enter;
    int unsigned                  gap;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_TICKS[i];
      if (i == 0 || row.gait != gait_reg) program_gait(row.gait);
      send_tick(row.fwd, row.turn, row.slider, row.enter, row.typed, row.report);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_gait(PHASE_GAITS[p]);
      // Rotate through a long receiver hold, sender idling, receiver stalling and both.
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          hold_requests++;
        end
        1: begin
          send_idle_pct = 70;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 70;
        end
        default: begin
          send_idle_pct = 31;
          stall_pct = 31;
        end
      endcase
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // Mostly in-range sticks and slider, some full-width values.
        case ($urandom_range(9))
          0: fwd = '0;
          1: fwd = (gpg_pkg::FWD_W)'($urandom_range(32767));
          default: fwd = (gpg_pkg::FWD_W)'($urandom_range(25600));
        endcase
        case ($urandom_range(9))
          0: turn = '0;
          1: turn = (gpg_pkg::TURN_W)'($urandom_range(65535));
          default: turn = (gpg_pkg::TURN_W)'(int'($urandom_range(51200)) - 25600);
        endcase
        slider = ($urandom_range(7) == 0) ? (gpg_pkg::SLIDER_W)'($urandom_range(127))
                                           : (gpg_pkg::SLIDER_W)'($urandom_range(100));
        enter = ($urandom_range(19) == 0);
        send_tick(fwd, turn, slider, enter, 1'b0, '0);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("Test completed with failures");
    $finish;
  end

endmodule
